>>> rtl/stereo_peak_limiter_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo peak limiter
// Shared forms for same-cycle and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_LIMITER_TOP_ASSERT_SVH
`define STEREO_PEAK_LIMITER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg
// Types and constants shared by the stereo peak limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int THRESH_W    = 23;
   localparam int COEF_W      = 24;
   localparam int GAIN_W      = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS   = 23;

   localparam logic [GAIN_W-1:0]   UNITY_GAIN      = 24'h800000;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 23'h7FFFFF;
   localparam logic [COEF_W-1:0]   RELEASE_RESET   = 24'd16710000;
   localparam logic [1:0]          CHANNELS_RESET  = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_RELEASE   = 2'd1,
      CSR_CHANNELS  = 2'd2,
      CSR_BYPASS    = 2'd3
   } csr_index_type;

   // One classified frame, with the settings that were in force when it arrived.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_ch0;
      logic [SAMPLE_W-1:0] sample_ch1;
      logic                block_end;
      logic                bypass;
      logic                two;
      logic                over;
      logic [THRESH_W-1:0] peak;
      logic [THRESH_W-1:0] threshold;
      logic [COEF_W-1:0]   coef;
   } spl_entry_type;

endpackage

`default_nettype wire

>>> rtl/spl_front.sv
// ----------------------------------------------------------------------------
// spl_front
// Holds the settings, accepts frames and finds each frame's peak and class.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_front import spl_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_W-1:0]    req_sample_ch0,
   input  wire logic [SAMPLE_W-1:0]    req_sample_ch1,
   input  wire logic                   req_block_end,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                        push_valid,
   input  wire logic                   push_ready,
   output spl_entry_type               push_entry
);

   localparam bit MULTI = (CHANNELS >= 2);

   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic [COEF_W-1:0]   coef_ff, coef_in;
   logic [1:0]          channels_ff, channels_in;
   logic                bypass_ff, bypass_in;

   logic [THRESH_W-1:0] mag0, mag1, peak;
   logic                two;

   // Magnitude with the most negative code saturated to full scale.
   function automatic logic [THRESH_W-1:0] mag(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] n;
      n = (~s) + 1'b1;
      if (!s[SAMPLE_W-1]) begin
         return s[THRESH_W-1:0];
      end else if (n[SAMPLE_W-1]) begin
         return THRESHOLD_RESET;
      end else begin
         return n[THRESH_W-1:0];
      end
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in = threshold_ff;
      coef_in      = coef_ff;
      channels_in  = channels_ff;
      bypass_in    = bypass_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_in = csr_wdata[THRESH_W-1:0];
            CSR_RELEASE:   coef_in      = csr_wdata[COEF_W-1:0];
            CSR_CHANNELS:  channels_in  = csr_wdata[1:0];
            CSR_BYPASS:    bypass_in    = csr_wdata[0];
            default:       threshold_in = threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         coef_ff      <= RELEASE_RESET;
         channels_ff  <= CHANNELS_RESET;
         bypass_ff    <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         coef_ff      <= coef_in;
         channels_ff  <= channels_in;
         bypass_ff    <= bypass_in;
      end
   end

   assign two  = MULTI && (channels_ff >= 2'd2);
   assign mag0 = mag(req_sample_ch0);
   assign mag1 = mag(req_sample_ch1);
   assign peak = (two && (mag1 > mag0)) ? mag1 : mag0;

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   always_comb begin
      push_entry.sample_ch0 = req_sample_ch0;
      push_entry.sample_ch1 = req_sample_ch1;
      push_entry.block_end  = req_block_end;
      push_entry.bypass     = bypass_ff;
      push_entry.two        = two;
      push_entry.over       = (peak > threshold_ff);
      push_entry.peak       = peak;
      push_entry.threshold  = threshold_ff;
      push_entry.coef       = coef_ff;
   end

endmodule

`default_nettype wire

>>> rtl/spl_queue.sv
// ----------------------------------------------------------------------------
// spl_queue
// Short first-in first-out queue of classified frames.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_queue import spl_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire spl_entry_type  push_entry,
   output logic                pop_valid,
   input  wire logic           pop_ready,
   output spl_entry_type       pop_entry
);

   localparam logic [QUEUE_PTR_W:0] FULL_COUNT = (QUEUE_PTR_W+1)'(QUEUE_DEPTH);

   spl_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/spl_back.sv
// ----------------------------------------------------------------------------
// spl_back
// Serial divider, release smoothing and sample scaling for one frame at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module spl_back import spl_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           pop_valid,
   output logic                pop_ready,
   input  wire spl_entry_type  pop_entry,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_out_ch0,
   output logic [SAMPLE_W-1:0] rsp_out_ch1,
   output logic                rsp_block_end_out,
   output logic [GAIN_W-1:0]   rsp_current_gain
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MIX,
      ST_SUM,
      ST_MUL,
      ST_DONE
   } state_type;

   localparam logic [4:0]  LAST_STEP = 5'(DIV_STEPS - 1);
   localparam logic [24:0] FULL_Q24  = 25'h1000000;

   state_type           state_ff;
   spl_entry_type       item_ff;
   logic [THRESH_W:0]   rem_ff;
   logic [THRESH_W-1:0] quot_ff;
   logic [4:0]          step_ff;
   logic [GAIN_W-1:0]   target_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [47:0]         prod_hold_ff, prod_rel_ff;
   logic signed [48:0]  prod0_ff, prod1_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] out_ch0_ff, out_ch1_ff;
   logic                block_end_ff;
   logic [GAIN_W-1:0]   gain_out_ff;

   logic [THRESH_W:0]   rem_shift, rem_in;
   logic [THRESH_W-1:0] quot_in;
   logic                fits;
   logic [24:0]         rel_coef;
   logic [47:0]         mul_hold;
   logic [48:0]         mul_rel;
   logic [47:0]         mix_sum;
   logic [GAIN_W-1:0]   mixed;
   logic signed [48:0]  mul0, mul1;
   logic                out_free;
   logic                out_load;

   // Restoring division: the remainder stays below the peak, so a shift never overflows.
   assign rem_shift = {rem_ff[THRESH_W-1:0], 1'b0};
   assign fits      = (rem_shift >= {1'b0, item_ff.peak});
   assign rem_in    = fits ? (rem_shift - {1'b0, item_ff.peak}) : rem_shift;
   assign quot_in   = {quot_ff[THRESH_W-2:0], fits};

   assign rel_coef = FULL_Q24 - {1'b0, item_ff.coef};
   assign mul_hold = item_ff.coef * gain_ff;
   assign mul_rel  = rel_coef * target_ff;
   assign mix_sum  = prod_hold_ff + prod_rel_ff;
   assign mixed    = mix_sum[47:24];

   assign mul0 = $signed(item_ff.sample_ch0) * $signed({1'b0, gain_ff});
   assign mul1 = $signed(item_ff.sample_ch1) * $signed({1'b0, gain_ff});

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (state_ff == ST_DONE) && out_free;
   assign pop_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  item_ff <= pop_entry;
                  rem_ff  <= {1'b0, pop_entry.threshold};
                  quot_ff <= '0;
                  step_ff <= '0;
                  if (pop_entry.bypass) begin
                     state_ff <= ST_DONE;
                  end else if (pop_entry.over) begin
                     state_ff <= ST_DIV;
                  end else begin
                     target_ff <= UNITY_GAIN;
                     state_ff  <= ST_MIX;
                  end
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               quot_ff <= quot_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  target_ff <= {1'b0, quot_in};
                  state_ff  <= ST_MIX;
               end
            end
            ST_MIX: begin
               // A lower target is taken at once; otherwise blend toward it.
               if (target_ff < gain_ff) begin
                  gain_ff  <= target_ff;
                  state_ff <= ST_MUL;
               end else begin
                  prod_hold_ff <= mul_hold;
                  prod_rel_ff  <= mul_rel[47:0];
                  state_ff     <= ST_SUM;
               end
            end
            ST_SUM: begin
               gain_ff  <= (mixed > UNITY_GAIN) ? UNITY_GAIN : mixed;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod0_ff <= mul0;
               prod1_ff <= mul1;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  block_end_ff <= item_ff.block_end;
                  if (item_ff.bypass) begin
                     out_ch0_ff  <= item_ff.sample_ch0;
                     out_ch1_ff  <= item_ff.sample_ch1;
                     gain_out_ff <= UNITY_GAIN;
                  end else begin
                     out_ch0_ff  <= prod0_ff[46:23];
                     out_ch1_ff  <= item_ff.two ? prod1_ff[46:23] : '0;
                     gain_out_ff <= gain_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_ch0       = out_ch0_ff;
   assign rsp_out_ch1       = out_ch1_ff;
   assign rsp_block_end_out = block_end_ff;
   assign rsp_current_gain  = gain_out_ff;

endmodule

`default_nettype wire

>>> rtl/stereo_peak_limiter_top.sv
// ----------------------------------------------------------------------------
// Stereo peak limiter
// Instant-attack, one-pole-release limiter for frames of two Q1.23 samples.
// Frames enter on the req_ channel and leave on the rsp_ channel, one result
// word per frame, in order. Settings are written on the csr_ channel, index
// 0 threshold, 1 release coefficient, 2 active channels, 3 bypass. The user
// writes them only while no frame is in flight; the block does not enforce
// this, and csr_ready is always high. A frame whose peak exceeds the
// threshold passes through the 23-step serial divider before smoothing and
// scaling, other frames skip the divider and bypass frames skip both. The
// back end works on one frame at a time; it takes the next after the last.
// A two-entry queue behind the front end takes up to two further frames while
// the back end works or waits on a stalled receiver; req_ready drops once the
// queue is full. The result holds in its output register until taken.
// Reset restores the default settings, sets the held gain to unity and
// empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_peak_limiter_top import spl_pkg::*; #(
   parameter int CHANNELS = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_W-1:0]    req_sample_ch0,
   input  wire logic [SAMPLE_W-1:0]    req_sample_ch1,
   input  wire logic                   req_block_end,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [SAMPLE_W-1:0]         rsp_out_ch0,
   output logic [SAMPLE_W-1:0]         rsp_out_ch1,
   output logic                        rsp_block_end_out,
   output logic [GAIN_W-1:0]           rsp_current_gain,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic          push_valid, push_ready;
   spl_entry_type push_entry;
   logic          pop_valid, pop_ready;
   spl_entry_type pop_entry;

   spl_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_ch0 (req_sample_ch0),
      .req_sample_ch1 (req_sample_ch1),
      .req_block_end  (req_block_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_entry     (push_entry)
   );

   spl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   spl_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_ch0       (rsp_out_ch0),
      .rsp_out_ch1       (rsp_out_ch1),
      .rsp_block_end_out (rsp_block_end_out),
      .rsp_current_gain  (rsp_current_gain)
   );

endmodule

`default_nettype wire

>>> rtl/spl_checker.sv
// ----------------------------------------------------------------------------
// spl_checker
// Port-level checks on the stereo peak limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_peak_limiter_top_assert.svh"

module spl_checker import spl_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [SAMPLE_W-1:0] rsp_out_ch0,
   input wire logic [SAMPLE_W-1:0] rsp_out_ch1,
   input wire logic [GAIN_W-1:0]   rsp_current_gain
);

   // A stalled result word keeps its samples and gain.
   `SPL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_ch0) && $stable(rsp_out_ch1) && $stable(rsp_current_gain), "stalled result changed")

   // The gain never rises above unity.
   `SPL_ASSERT_NOW(a_gain_max, clock, reset, rsp_valid, rsp_current_gain <= UNITY_GAIN, "gain above unity")

   // A zero gain must silence both outputs.
   `SPL_ASSERT_NOW(a_silence, clock, reset, rsp_valid && (rsp_current_gain == '0), (rsp_out_ch0 == '0) && (rsp_out_ch1 == '0), "zero gain did not silence")

   // Reset leaves no result pending and room for a new frame.
   `SPL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "reset did not empty the block")

endmodule

bind stereo_peak_limiter_top spl_checker u_checker (.*);

`default_nettype wire
